[design/bbpc_pkg.sv]
// ----------------------------------------------------------------------------
// Bidirectional beam pass counter package
// Widths, register indexes and result codes that are shared by the interfaces
// and the counter.
// ----------------------------------------------------------------------------
package bbpc_pkg;

  localparam int TIME_BITS  = 32;
  localparam int COUNT_BITS = 16;
  localparam int REG_BITS   = 16;
  localparam int PULSE_BITS = 16;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [REG_BITS-1:0] WINDOW_RESET = REG_BITS'(700);
  localparam logic [REG_BITS-1:0] PULSE_RESET  = REG_BITS'(1000);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WINDOW = 1'b0,
    CFG_PULSE  = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    EVT_NONE = 2'd0,
    EVT_IN   = 2'd1,
    EVT_OUT  = 2'd2
  } pass_event_t;

  typedef logic [TIME_BITS-1:0]  time_t;
  typedef logic [COUNT_BITS-1:0] count_t;

endpackage

[design/bbpc_in_if.sv]
// ----------------------------------------------------------------------------
// Bidirectional beam pass counter input channel
// One word per tick, carrying the rising-edge flags of both sensors.
// ----------------------------------------------------------------------------
interface bbpc_in_if;

  logic valid;
  logic ready;
  logic edge_a;
  logic edge_b;

  modport source (output valid, output edge_a, output edge_b, input ready);
  modport sink   (input valid, input edge_a, input edge_b, output ready);

endinterface

[design/bbpc_out_if.sv]
// ----------------------------------------------------------------------------
// Bidirectional beam pass counter output channel
// One word per tick with the counts, the pulse state and the pass event.
// ----------------------------------------------------------------------------
interface bbpc_out_if;
  import bbpc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] in_passes;
  logic [COUNT_BITS-1:0] out_passes;
  logic signed [COUNT_BITS:0] net_count;
  logic [COUNT_BITS:0]   total_count;
  logic                  pulse_out;
  logic [1:0]            pass_event;

  modport source (output valid, output in_passes, output out_passes, output net_count,
                  output total_count, output pulse_out, output pass_event, input ready);
  modport sink   (input valid, input in_passes, input out_passes, input net_count,
                  input total_count, input pulse_out, input pass_event, output ready);

endinterface

[design/bidirectional_beam_pass_counter_unit.sv]
// ----------------------------------------------------------------------------
// Bidirectional beam pass counter
// Debounces two beam sensors, pairs their edges into in and out passes and
// keeps wrapping in and out counts, with an indicator pulse after each pass.
//
//   channel   dir   handshake      payload
//   in_ch     in    valid/ready    edge_a, edge_b
//   out_ch    out   valid/ready    in_passes, out_passes, net_count,
//                                  total_count, pulse_out, pass_event
//   cfg       in    cfg_we         cfg_index, cfg_data
//
// One word is accepted every cycle while the output does not stall; a
// result passes through the input register and then the result register.
// The state and the result register advance together, so a stall
// on the output holds the input register and then drops in_ch.ready.
// Reset clears all counters, time stamps and the pulse, and loads the
// register defaults.
// ----------------------------------------------------------------------------
module bidirectional_beam_pass_counter_unit (
  input  logic                           clk,
  input  logic                           rst,
  bbpc_in_if.sink                        in_ch,
  bbpc_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [bbpc_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [bbpc_pkg::REG_BITS-1:0]  cfg_data
);
  import bbpc_pkg::*;

  logic [REG_BITS-1:0]   window_ticks;
  logic [REG_BITS-1:0]   pulse_ticks;

  logic                  s1_valid;
  logic                  s1_edge_a;
  logic                  s1_edge_b;

  time_t                 tick_now;
  time_t                 last_edge_a;
  time_t                 last_edge_b;
  time_t                 stamp_a;
  time_t                 stamp_b;
  logic                  armed_a;
  logic                  armed_b;
  count_t                in_total;
  count_t                out_total;
  logic [PULSE_BITS-1:0] pulse_left;

  time_t                 tick_now_next;
  time_t                 last_edge_a_next;
  time_t                 last_edge_b_next;
  time_t                 stamp_a_next;
  time_t                 stamp_b_next;
  logic                  armed_a_next;
  logic                  armed_b_next;
  count_t                in_total_next;
  count_t                out_total_next;
  logic [PULSE_BITS-1:0] pulse_left_next;
  pass_event_t           event_next;

  time_t                 window_wide;
  time_t                 age_a;
  time_t                 age_b;
  logic                  take_a;
  logic                  take_b;
  logic                  live_a;
  logic                  live_b;
  logic                  held;
  logic                  pair;

  logic                  res_valid;
  count_t                res_in_passes;
  count_t                res_out_passes;
  logic signed [COUNT_BITS:0] res_net;
  logic [COUNT_BITS:0]   res_total;
  logic                  res_pulse;
  pass_event_t           res_event;

  logic                  advance;
  logic                  s1_fire;

  assign advance      = !res_valid || out_ch.ready;
  assign s1_fire      = s1_valid && advance;
  assign in_ch.ready  = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks <= WINDOW_RESET;
      pulse_ticks  <= PULSE_RESET;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_WINDOW: window_ticks <= cfg_data;
        CFG_PULSE:  pulse_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_edge_a <= in_ch.edge_a;
      s1_edge_b <= in_ch.edge_b;
    end
  end

  always_comb begin
    window_wide = TIME_BITS'(window_ticks);

    take_a = s1_edge_a && ((tick_now - last_edge_a) > window_wide);
    take_b = s1_edge_b && ((tick_now - last_edge_b) > window_wide);

    last_edge_a_next = s1_edge_a ? tick_now : last_edge_a;
    last_edge_b_next = s1_edge_b ? tick_now : last_edge_b;
    stamp_a_next     = take_a ? tick_now : stamp_a;
    stamp_b_next     = take_b ? tick_now : stamp_b;

    age_a = take_a ? '0 : tick_now - stamp_a;
    age_b = take_b ? '0 : tick_now - stamp_b;

    live_a = (armed_a || take_a) && (age_a < window_wide);
    live_b = (armed_b || take_b) && (age_b < window_wide);

    held = (pulse_left != '0);
    pair = !held && live_a && live_b;

    armed_a_next   = live_a && !pair;
    armed_b_next   = live_b && !pair;
    in_total_next  = in_total;
    out_total_next = out_total;
    event_next     = EVT_NONE;
    if (held) begin
      pulse_left_next = pulse_left - 1'b1;
    end else if (pair) begin
      pulse_left_next = PULSE_BITS'(pulse_ticks);
    end else begin
      pulse_left_next = pulse_left;
    end
    if (pair) begin
      if (age_a < age_b) begin
        in_total_next = in_total + 1'b1;
        event_next    = EVT_IN;
      end else begin
        out_total_next = out_total + 1'b1;
        event_next     = EVT_OUT;
      end
    end

    tick_now_next = tick_now + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_now    <= '0;
      last_edge_a <= '0;
      last_edge_b <= '0;
      stamp_a     <= '0;
      stamp_b     <= '0;
      armed_a     <= 1'b0;
      armed_b     <= 1'b0;
      in_total    <= '0;
      out_total   <= '0;
      pulse_left  <= '0;
    end else if (s1_fire) begin
      tick_now    <= tick_now_next;
      last_edge_a <= last_edge_a_next;
      last_edge_b <= last_edge_b_next;
      stamp_a     <= stamp_a_next;
      stamp_b     <= stamp_b_next;
      armed_a     <= armed_a_next;
      armed_b     <= armed_b_next;
      in_total    <= in_total_next;
      out_total   <= out_total_next;
      pulse_left  <= pulse_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res_in_passes  <= in_total_next;
      res_out_passes <= out_total_next;
      res_net        <= signed'({1'b0, in_total_next} - {1'b0, out_total_next});
      res_total      <= {1'b0, in_total_next} + {1'b0, out_total_next};
      res_pulse      <= held;
      res_event      <= event_next;
    end
  end

  assign out_ch.valid       = res_valid;
  assign out_ch.in_passes   = res_in_passes;
  assign out_ch.out_passes  = res_out_passes;
  assign out_ch.net_count   = res_net;
  assign out_ch.total_count = res_total;
  assign out_ch.pulse_out   = res_pulse;
  assign out_ch.pass_event  = res_event;

endmodule

[verif/bbpc_checker.sv]
// ----------------------------------------------------------------------------
// Bidirectional beam pass counter checker
// Watches the input, output and register write ports of the counter. For
// each input word taken it advances its own copy of the debounce, pairing,
// pulse and count state and queues the result word that the counter must
// give. Each result word taken is compared field by field with the oldest
// queued word. Failures and progress counts are handed to the testbench top.
// ----------------------------------------------------------------------------
module bbpc_checker (
  input  logic                              clk,
  input  logic                              rst,
  bbpc_in_if                                in_ch,
  bbpc_out_if                               out_ch,
  input  logic                              cfg_we,
  input  logic [bbpc_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [bbpc_pkg::REG_BITS-1:0]     cfg_data,
  output int                                errors,
  output int                                pending,
  output int                                checked,
  output int                                passes
);
  timeunit 1ns;
  timeprecision 1ps;
  import bbpc_pkg::*;

  typedef struct {
    count_t                     in_passes;
    count_t                     out_passes;
    logic signed [COUNT_BITS:0] net_count;
    logic [COUNT_BITS:0]        total_count;
    logic                       pulse_out;
    pass_event_t                pass_event;
  } tally_t;

  time_t                 now_tick;
  time_t                 last_a;
  time_t                 last_b;
  time_t                 stamp_a;
  time_t                 stamp_b;
  logic                  armed_a;
  logic                  armed_b;
  count_t                in_count;
  count_t                out_count;
  logic [PULSE_BITS-1:0] hold_left;
  logic [REG_BITS-1:0]   window;
  logic [REG_BITS-1:0]   pulse_len;

  tally_t tally_q[$];
  int     err_count;
  int     check_count;
  int     pass_count;

  initial begin
    err_count   = 0;
    check_count = 0;
    pass_count  = 0;
  end

  function automatic tally_t advance_tick(input logic a, input logic b);
    tally_t      t;
    time_t       age_last;
    time_t       age_a;
    time_t       age_b;
    logic        held;
    pass_event_t ev;
    ev = EVT_NONE;
    if (a) begin
      age_last = now_tick - last_a;
      if (age_last > window) begin
        stamp_a = now_tick;
        armed_a = 1'b1;
      end
      last_a = now_tick;
    end
    if (b) begin
      age_last = now_tick - last_b;
      if (age_last > window) begin
        stamp_b = now_tick;
        armed_b = 1'b1;
      end
      last_b = now_tick;
    end
    age_a = now_tick - stamp_a;
    age_b = now_tick - stamp_b;
    if (armed_a && age_a >= window) armed_a = 1'b0;
    if (armed_b && age_b >= window) armed_b = 1'b0;
    held = (hold_left != '0);
    if (held) begin
      hold_left = hold_left - 1'b1;
    end else if (armed_a && armed_b) begin
      if (age_a < age_b) begin
        in_count = in_count + 1'b1;
        ev = EVT_IN;
      end else begin
        out_count = out_count + 1'b1;
        ev = EVT_OUT;
      end
      armed_a = 1'b0;
      armed_b = 1'b0;
      hold_left = pulse_len;
    end
    now_tick = now_tick + 1'b1;
    t.in_passes   = in_count;
    t.out_passes  = out_count;
    t.net_count   = {1'b0, in_count} - {1'b0, out_count};
    t.total_count = {1'b0, in_count} + {1'b0, out_count};
    t.pulse_out   = held;
    t.pass_event  = ev;
    return t;
  endfunction

  always @(posedge clk) begin : watch
    tally_t want;
    if (rst) begin
      now_tick  = '0;
      last_a    = '0;
      last_b    = '0;
      stamp_a   = '0;
      stamp_b   = '0;
      armed_a   = 1'b0;
      armed_b   = 1'b0;
      in_count  = '0;
      out_count = '0;
      hold_left = '0;
      window    = WINDOW_RESET;
      pulse_len = PULSE_RESET;
      tally_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_WINDOW) window = cfg_data;
        else if (cfg_index == CFG_PULSE) pulse_len = cfg_data;
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        tally_q.push_back(advance_tick(in_ch.edge_a, in_ch.edge_b));
      end
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (tally_q.size() == 0) begin
          $error("Result word arrived with no expected word waiting.");
          err_count++;
        end else begin
          want = tally_q.pop_front();
          if (out_ch.in_passes !== want.in_passes) begin
            $error("in_passes: expected %0d, got %0d", want.in_passes, out_ch.in_passes);
            err_count++;
          end
          if (out_ch.out_passes !== want.out_passes) begin
            $error("out_passes: expected %0d, got %0d", want.out_passes,
                   out_ch.out_passes);
            err_count++;
          end
          if (out_ch.net_count !== want.net_count) begin
            $error("net_count: expected %0d, got %0d", want.net_count, out_ch.net_count);
            err_count++;
          end
          if (out_ch.total_count !== want.total_count) begin
            $error("total_count: expected %0d, got %0d", want.total_count,
                   out_ch.total_count);
            err_count++;
          end
          if (out_ch.pulse_out !== want.pulse_out) begin
            $error("pulse_out: expected %0d, got %0d", want.pulse_out, out_ch.pulse_out);
            err_count++;
          end
          if (out_ch.pass_event !== want.pass_event) begin
            $error("pass_event: expected %0d, got %0d", want.pass_event,
                   out_ch.pass_event);
            err_count++;
          end
          check_count++;
          if (want.pass_event != EVT_NONE) pass_count++;
        end
      end
    end
    errors  <= err_count;
    pending <= tally_q.size();
    checked <= check_count;
    passes  <= pass_count;
  end

endmodule

[verif/bidirectional_beam_pass_counter_unit_tb.sv]
// ----------------------------------------------------------------------------
// Bidirectional beam pass counter testbench
// Drives tick words of sensor edge flags into the counter: a short directed
// run through debounce, pairing, ties, expiry and zero registers, then
// random pass attempts and noise over several register settings and three
// handshake pacing profiles. A checker beside the counter predicts and
// compares every result word.
// ----------------------------------------------------------------------------
module bidirectional_beam_pass_counter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bbpc_pkg::*;

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [REG_BITS-1:0]     cfg_data;

  int src_idle_pct;
  int dst_idle_pct;
  int sent;
  int cur_window;
  int errors;
  int pending;
  int checked;
  int passes;

  bbpc_in_if  in_ch ();
  bbpc_out_if out_ch ();

  bidirectional_beam_pass_counter_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bbpc_checker tally_check (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked),
    .passes    (passes)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= dst_idle_pct);
  end

  task automatic send_word(input logic a, input logic b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.edge_a <= a;
    in_ch.edge_b <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sent++;
  endtask

  task automatic send_quiet(input int n);
    repeat (n) send_word(1'b0, 1'b0);
  endtask

  task automatic send_pattern(input string s);
    for (int i = 0; i < s.len(); i++) begin
      case (s[i])
        "a": send_word(1'b1, 1'b0);
        "b": send_word(1'b0, 1'b1);
        "x": send_word(1'b1, 1'b1);
        default: send_word(1'b0, 1'b0);
      endcase
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_registers(input int w, input int p);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WINDOW;
    cfg_data  <= REG_BITS'(w);
    @(posedge clk);
    cfg_index <= CFG_PULSE;
    cfg_data  <= REG_BITS'(p);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_window = w;
  endtask

  task automatic pass_attempt();
    int gap;
    int first;
    int d;
    if ($urandom_range(9) < 8) gap = cur_window + 1 + $urandom_range(3);
    else gap = $urandom_range(cur_window);
    send_quiet(gap);
    first = $urandom_range(2);
    send_word(first != 1, first != 0);
    if (first != 2) begin
      if (cur_window > 1 && $urandom_range(4) != 0) d = $urandom_range(cur_window - 1, 1);
      else d = cur_window + $urandom_range(1);
      if (d == 0) d = 1;
      repeat (d - 1) begin
        send_word(first == 0 && $urandom_range(9) == 0, first == 1 && $urandom_range(9) == 0);
      end
      send_word(first == 1, first == 0);
    end
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(8, 1)) send_word($urandom_range(3) == 0, $urandom_range(3) == 0);
  endtask

  task automatic random_setting();
    int w;
    int p;
    case ($urandom_range(9))
      0: w = 1;
      1: w = 2;
      2: w = 0;
      default: w = $urandom_range(40, 3);
    endcase
    case ($urandom_range(5))
      0: p = 0;
      1: p = 1;
      default: p = $urandom_range(30, 2);
    endcase
    load_registers(w, p);
  endtask

  initial begin
    int start;
    in_ch.valid  <= 1'b0;
    in_ch.edge_a <= 1'b0;
    in_ch.edge_b <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_WINDOW;
    cfg_data     <= '0;
    rst          <= 1'b1;
    src_idle_pct = 15;
    dst_idle_pct = 77;
    sent         = 0;
    cur_window   = WINDOW_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_pattern("xab.");
    load_registers(3, 2);
    send_pattern("....ab....ba....x....a...b");
    load_registers(0, 0);
    send_pattern("x.x");

    for (int stage = 0; stage < 3; stage++) begin
      case (stage)
        0: begin
          src_idle_pct = 15;
          dst_idle_pct = 77;
        end
        1: begin
          src_idle_pct = 77;
          dst_idle_pct = 15;
        end
        default: begin
          src_idle_pct = 0;
          dst_idle_pct = 0;
        end
      endcase
      repeat (4) begin
        random_setting();
        start = sent;
        while (sent - start < 145) begin
          if ($urandom_range(9) < 8) pass_attempt();
          else noise_burst();
        end
      end
    end

    settle();
    $display("Run summary: %0d words sent, %0d result words checked, %0d passes counted.",
             sent, checked, passes);
    $display("Covered zero and small registers, ties, expiry and three pacing profiles.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $error("Run did not finish in the allotted time.");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
